// ===== rtl/cbsec_pkg.sv =====
// ---------------------------------------------------------------------------
// cbsec_pkg
// Shared types, codes and position helpers for the cache block SECDED
// check and correct block.
// ---------------------------------------------------------------------------
package cbsec_pkg;

   localparam int WORD_W    = 64;
   localparam int CNT_MAX_W = 5;
   localparam int CHK_MAX_W = 11;
   localparam int CHK_OUT_W = 10;
   localparam int ERR_OUT_W = 9;
   localparam int ERR_W     = 16;

   typedef enum logic {
      FUNC_ENCODE = 1'b0,
      FUNC_CHECK  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STAT_CLEAN     = 2'd0,
      STAT_CORRECTED = 2'd1,
      STAT_REFRESH   = 2'd2,
      STAT_FATAL     = 2'd3
   } status_type;

   // block summary handed from the front to the back
   typedef struct packed {
      func_type               func;
      logic [CNT_MAX_W-1:0]   n;
      logic [CHK_MAX_W-1:0]   chk;
      logic                   ov;
      logic [CHK_MAX_W-1:0]   scb;
      logic                   sov;
   } desc_type;

   // codeword position of data bit d: the d-th non-power-of-two from 1
   function automatic int unsigned data_pos(int unsigned d);
      int unsigned pos;
      int unsigned j;
      pos = d + 1;
      j   = 0;
      while (j < 31 && (32'd1 << j) <= pos) begin
         pos++;
         j++;
      end
      return pos;
   endfunction

   // bit b set when data bit b of word w feeds check bit p
   function automatic logic [WORD_W-1:0] chk_mask(int unsigned w, int unsigned p);
      logic [WORD_W-1:0] m;
      int unsigned       pos;
      m = '0;
      for (int unsigned b = 0; b < WORD_W; b++) begin
         pos  = data_pos(w * WORD_W + b);
         m[b] = ((pos >> p) & 1) != 0;
      end
      return m;
   endfunction

endpackage

// ===== rtl/cbsec_queue.sv =====
// ---------------------------------------------------------------------------
// cbsec_queue
// Two-entry queue of block summaries. The slot number of each entry also
// names the word buffer bank that holds the block's words.
// ---------------------------------------------------------------------------
module cbsec_queue
   import cbsec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head,
   output logic     empty,
   output logic     full,
   output logic     wr_slot,
   output logic     rd_slot
);

   desc_type   slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty   = (cnt_ff == 2'd0);
   assign full    = (cnt_ff == 2'd2);
   assign head    = slot_ff[rp_ff];
   assign wr_slot = wp_ff;
   assign rd_slot = rp_ff;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/cbsec_front.sv =====
// ---------------------------------------------------------------------------
// cbsec_front
// Accepts block words, writes them to the free buffer bank and folds them
// into the running check bits and overall parity; pushes a block summary
// on the last word.
// ---------------------------------------------------------------------------
module cbsec_front
   import cbsec_pkg::*;
#(
   parameter int BLOCK_WORDS = 8,
   parameter int CHECK_BITS  = 10,
   parameter int IDX_W       = 3,
   parameter int CNT_W       = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [WORD_W-1:0]     req_data_word,
   input  logic                  req_word_last,
   input  logic [CHK_OUT_W-1:0]  req_stored_check_bits,
   input  logic                  req_stored_overall,
   input  logic                  q_full,
   input  logic                  wr_slot,
   output logic                  mem_wr_en,
   output logic [IDX_W:0]        mem_wr_addr,
   output logic [WORD_W-1:0]     mem_wr_data,
   output logic                  push,
   output desc_type              push_desc
);

   logic [WORD_W-1:0]     mask_tab [BLOCK_WORDS][CHECK_BITS];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CHECK_BITS-1:0] chk_ff, chk_in;
   logic                  ov_ff, ov_in;
   logic                  accept;
   logic                  room;
   logic [IDX_W-1:0]      idx;
   logic [CHECK_BITS-1:0] contrib;
   logic [CNT_W-1:0]      count_next;
   logic [CHECK_BITS-1:0] chk_next;
   logic                  ov_next;

   for (genvar gw = 0; gw < BLOCK_WORDS; gw++) begin : g_word
      for (genvar gp = 0; gp < CHECK_BITS; gp++) begin : g_bit
         assign mask_tab[gw][gp] = chk_mask(gw, gp);
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(BLOCK_WORDS));
   assign idx       = count_ff[IDX_W-1:0];

   always_comb begin
      for (int p = 0; p < CHECK_BITS; p++) begin
         contrib[p] = ^(req_data_word & mask_tab[idx][p]);
      end
   end

   always_comb begin
      count_next = count_ff;
      chk_next   = chk_ff;
      ov_next    = ov_ff;
      if (room) begin
         count_next = count_ff + CNT_W'(1);
         chk_next   = chk_ff ^ contrib;
         ov_next    = ov_ff ^ (^req_data_word);
      end
   end

   assign mem_wr_en   = accept && room;
   assign mem_wr_addr = {wr_slot, idx};
   assign mem_wr_data = req_data_word;

   assign push           = accept && req_word_last;
   assign push_desc.func = func_type'(req_func);
   assign push_desc.n    = CNT_MAX_W'(count_next);
   assign push_desc.chk  = CHK_MAX_W'(chk_next);
   assign push_desc.ov   = ov_next;
   assign push_desc.scb  = CHK_MAX_W'(CHECK_BITS'(req_stored_check_bits));
   assign push_desc.sov  = req_stored_overall;

   always_comb begin
      count_in = count_ff;
      chk_in   = chk_ff;
      ov_in    = ov_ff;
      if (accept) begin
         if (req_word_last) begin
            count_in = '0;
            chk_in   = '0;
            ov_in    = 1'b0;
         end else begin
            count_in = count_next;
            chk_in   = chk_next;
            ov_in    = ov_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         chk_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         chk_ff   <= chk_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

// ===== rtl/cbsec_back.sv =====
// ---------------------------------------------------------------------------
// cbsec_back
// Holds the two-bank word buffer, decodes the check-block syndrome at the head
// then replays its words corrected; encode results share the result register.
// ---------------------------------------------------------------------------
module cbsec_back
   import cbsec_pkg::*;
#(
   parameter int CHECK_BITS = 10,
   parameter int IDX_W      = 3
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mem_wr_en,
   input  logic [IDX_W:0]        mem_wr_addr,
   input  logic [WORD_W-1:0]     mem_wr_data,
   input  desc_type              head,
   input  logic                  q_empty,
   input  logic                  rd_slot,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_out_word,
   output logic                  rsp_out_last,
   output logic [1:0]            rsp_status,
   output logic [CHK_OUT_W-1:0]  rsp_check_bits,
   output logic                  rsp_overall_parity,
   output logic [ERR_OUT_W-1:0]  rsp_error_bit_index
);

   localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   logic [WORD_W-1:0]    word_mem [MEM_DEPTH];
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_idx;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   status_type           status_ff, status_in;
   logic [ERR_W-1:0]     err_ff, err_in;
   logic                 flip_ff, flip_in;

   logic                 valid_ff, valid_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 last_ff, last_in;
   status_type           ostat_ff, ostat_in;
   logic [CHK_OUT_W-1:0] ochk_ff, ochk_in;
   logic                 oov_ff, oov_in;
   logic [ERR_OUT_W-1:0] oerr_ff, oerr_in;

   logic                  out_free;
   logic [CHECK_BITS-1:0] syn;
   logic                  mis;
   logic [3:0]            lead;
   logic [ERR_W-1:0]      d_pos;
   logic [ERR_W-1:0]      lim;
   status_type            dec_status;
   logic [ERR_W-1:0]      dec_err;
   logic                  dec_flip;
   logic                  is_last;
   logic [WORD_W-1:0]     fixed_word;

   // syndrome decode for the block at the head
   always_comb begin
      syn  = head.chk[CHECK_BITS-1:0] ^ head.scb[CHECK_BITS-1:0];
      mis  = head.ov ^ head.sov;
      lead = '0;
      for (int i = 0; i < CHECK_BITS; i++) begin
         if (syn[i]) begin
            lead = 4'(i);
         end
      end
      d_pos      = ERR_W'(syn) - ERR_W'(lead) - ERR_W'(2);
      lim        = ERR_W'(head.n) << 6;
      dec_status = STAT_FATAL;
      dec_err    = '0;
      dec_flip   = 1'b0;
      if (syn == '0 && !mis) begin
         dec_status = STAT_CLEAN;
      end else if (syn != '0 && mis) begin
         if ((syn & (syn - CHECK_BITS'(1))) == '0) begin
            dec_status = STAT_REFRESH;
         end else if (d_pos < lim) begin
            dec_status = STAT_CORRECTED;
            dec_err    = d_pos;
            dec_flip   = 1'b1;
         end
      end
   end

   assign out_free = !valid_ff || rsp_ready;
   assign is_last  = ((CNT_MAX_W'(k_ff) + CNT_MAX_W'(1)) == head.n);

   always_comb begin
      fixed_word = rd_data_ff;
      if (flip_ff && (err_ff[ERR_W-1:6] == (ERR_W - 6)'(k_ff))) begin
         fixed_word = rd_data_ff ^ (WORD_W'(1) << err_ff[5:0]);
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      status_in = status_ff;
      err_in    = err_ff;
      flip_in   = flip_ff;
      rd_en     = 1'b0;
      rd_idx    = k_ff;
      pop       = 1'b0;
      valid_in  = valid_ff && !rsp_ready;
      word_in   = word_ff;
      last_in   = last_ff;
      ostat_in  = ostat_ff;
      ochk_in   = ochk_ff;
      oov_in    = oov_ff;
      oerr_in   = oerr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (head.func == FUNC_ENCODE) begin
                  if (out_free) begin
                     valid_in = 1'b1;
                     word_in  = '0;
                     last_in  = 1'b1;
                     ostat_in = STAT_CLEAN;
                     ochk_in  = CHK_OUT_W'(head.chk);
                     oov_in   = head.ov;
                     oerr_in  = '0;
                     pop      = 1'b1;
                  end
               end else begin
                  status_in = dec_status;
                  err_in    = dec_err;
                  flip_in   = dec_flip;
                  k_in      = '0;
                  rd_en     = 1'b1;
                  rd_idx    = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               valid_in = 1'b1;
               word_in  = fixed_word;
               last_in  = is_last;
               ostat_in = status_ff;
               ochk_in  = CHK_OUT_W'(head.chk);
               oov_in   = head.ov;
               oerr_in  = err_ff[ERR_OUT_W-1:0];
               if (is_last) begin
                  pop      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  k_in   = k_ff + IDX_W'(1);
                  rd_en  = 1'b1;
                  rd_idx = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         word_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= word_mem[{rd_slot, rd_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      status_ff <= status_in;
      err_ff    <= err_in;
      flip_ff   <= flip_in;
      word_ff   <= word_in;
      last_ff   <= last_in;
      ostat_ff  <= ostat_in;
      ochk_ff   <= ochk_in;
      oov_ff    <= oov_in;
      oerr_ff   <= oerr_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_word        = word_ff;
   assign rsp_out_last        = last_ff;
   assign rsp_status          = ostat_ff;
   assign rsp_check_bits      = ochk_ff;
   assign rsp_overall_parity  = oov_ff;
   assign rsp_error_bit_index = oerr_ff;

endmodule

// ===== rtl/cache_block_secded_check_correct_top.sv =====
// ---------------------------------------------------------------------------
// cache_block_secded_check_correct_top
// Hamming SECDED encode or check and correct over a cache block of 64-bit
// words: front accumulator, two-entry block queue, replaying back end.
// ---------------------------------------------------------------------------
// Input: one word per cycle while not full; two blocks may be buffered (one per bank).
// Encode: the summary is queued, then a single result is registered; check: the
//   summary is queued, then decoded while the first word is read from the buffer,
//   then one corrected word per cycle through the buffer read port unless stalled.
// Sustained: a word per cycle in while the queue has room; back does one block at a time.
// Reset: synchronous; clears counts, running parity, queue and result valid.
module cache_block_secded_check_correct_top
   import cbsec_pkg::*;
#(
   parameter int BLOCK_WORDS = 8,
   parameter int CHECK_BITS  = 10
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [WORD_W-1:0]     req_data_word,
   input  logic                  req_word_last,
   input  logic [CHK_OUT_W-1:0]  req_stored_check_bits,
   input  logic                  req_stored_overall,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_out_word,
   output logic                  rsp_out_last,
   output logic [1:0]            rsp_status,
   output logic [CHK_OUT_W-1:0]  rsp_check_bits,
   output logic                  rsp_overall_parity,
   output logic [ERR_OUT_W-1:0]  rsp_error_bit_index
);

   localparam int IDX_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int CNT_W = $clog2(BLOCK_WORDS + 1);

   logic             q_full;
   logic             q_empty;
   logic             wr_slot;
   logic             rd_slot;
   logic             push;
   logic             pop;
   desc_type         push_desc;
   desc_type         head;
   logic             mem_wr_en;
   logic [IDX_W:0]   mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;

   cbsec_front #(
      .BLOCK_WORDS (BLOCK_WORDS),
      .CHECK_BITS  (CHECK_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_data_word         (req_data_word),
      .req_word_last         (req_word_last),
      .req_stored_check_bits (req_stored_check_bits),
      .req_stored_overall    (req_stored_overall),
      .q_full                (q_full),
      .wr_slot               (wr_slot),
      .mem_wr_en             (mem_wr_en),
      .mem_wr_addr           (mem_wr_addr),
      .mem_wr_data           (mem_wr_data),
      .push                  (push),
      .push_desc             (push_desc)
   );

   cbsec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full),
      .wr_slot   (wr_slot),
      .rd_slot   (rd_slot)
   );

   cbsec_back #(
      .CHECK_BITS (CHECK_BITS),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .head                (head),
      .q_empty             (q_empty),
      .rd_slot             (rd_slot),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_word        (rsp_out_word),
      .rsp_out_last        (rsp_out_last),
      .rsp_status          (rsp_status),
      .rsp_check_bits      (rsp_check_bits),
      .rsp_overall_parity  (rsp_overall_parity),
      .rsp_error_bit_index (rsp_error_bit_index)
   );

endmodule
